>>> src/wsaf_pkg.sv
package wsaf_pkg;

    // Default build values
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration register widths and reset values
    localparam int                 THETA_W     = 12;
    localparam int                 WLEN_W      = 7;
    localparam logic [THETA_W-1:0] THETA_RESET = 12'd768;
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 7'd16;

    // APB register map: register index sits in one address bit
    localparam int   APB_AW      = 3;
    localparam int   APB_DW      = 32;
    localparam int   APB_IDX_BIT = 2;
    localparam logic REG_THETA   = 1'b0;
    localparam logic REG_WLEN    = 1'b1;

    // Threshold arithmetic
    localparam int T2_W    = 2 * THETA_W;
    localparam int Q_SHIFT = 16;

    // Result index
    localparam int WCNT_W = 16;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [THETA_W-1:0] theta;
        logic [WLEN_W-1:0]  wlen;
        logic               clear;
    } cfg_t;

    typedef struct packed {
        logic present;
        logic new_stream;
    } item_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_OLD,
        ST_THETA,
        ST_SUM_MEAN,
        ST_CNT_MEAN,
        ST_MEAN_SQ,
        ST_CNT_DIFF,
        ST_DIFF_SQ,
        ST_DEV_LO,
        ST_DEV_HI,
        ST_RHS,
        ST_RESULT
    } back_state_t;

endpackage

>>> src/wsaf_sample_if.sv
interface wsaf_sample_if #(
    parameter int SAMPLE_BITS = wsaf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          sample_present;
    logic signed [SAMPLE_BITS-1:0] window_mean;
    logic                          new_stream;

    modport source (
        output valid,
        output sample_value,
        output sample_present,
        output window_mean,
        output new_stream,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_value,
        input  sample_present,
        input  window_mean,
        input  new_stream,
        output ready
    );
endinterface

>>> src/wsaf_result_if.sv
interface wsaf_result_if;
    import wsaf_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_anomaly;
    logic              empty_window;
    logic [WCNT_W-1:0] window_start;

    modport source (
        output valid,
        output is_anomaly,
        output empty_window,
        output window_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  is_anomaly,
        input  empty_window,
        input  window_start,
        output ready
    );
endinterface

>>> src/window_sigma_anomaly_flag.sv
// Sliding-window sigma anomaly flag.
// Requests enter on the samples channel (valid/ready): a signed reading, its
// present bit, the mean of the window ending at it, and a new_stream bit that
// restarts the window before this reading. Once window_length readings have
// arrived, every request yields one result on the results channel: is_anomaly
// is low only when the window is empty or the last present reading lies
// strictly inside mean +/- theta sigma; empty_window is high when the window
// holds no present reading. Registers on the APB port: theta_q8 at 0x0,
// window_length at 0x4 (a write there restarts the window). Write registers
// only while the block is idle. Once the window is full, a request steps the
// back end from ST_SQ_OLD through ST_THETA, the mean and deviation products,
// ST_RHS and ST_RESULT; while the window is still filling it returns to idle
// after ST_THETA. All products go through one shared multiplier stepped by
// the sequencer. A two-entry queue takes requests while the back end works;
// when the receiver stalls the result register holds, the back end waits,
// and ready drops once the queue is full. Reset: theta 3.0, window length 16,
// window and index cleared. The window store needs no clearing pass: only
// entries written since the last restart are read.
module window_sigma_anomaly_flag #(
    parameter int WINDOW_MAX  = wsaf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = wsaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    wsaf_sample_if.sink                 samples,
    wsaf_result_if.source               results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wsaf_pkg::APB_AW-1:0] paddr,
    input  logic [wsaf_pkg::APB_DW-1:0] pwdata,
    output logic [wsaf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import wsaf_pkg::*;

    cfg_t                          cfg;
    logic                          head_valid;
    logic signed [SAMPLE_BITS-1:0] head_value;
    logic signed [SAMPLE_BITS-1:0] head_mean;
    item_flags_t                   head_flags;
    logic                          pop;

    // Configuration registers
    wsaf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept and queue requests
    wsaf_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .head_valid (head_valid),
        .head_value (head_value),
        .head_mean  (head_mean),
        .head_flags (head_flags),
        .pop        (pop)
    );

    // Window update and threshold test
    wsaf_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_value (head_value),
        .head_mean  (head_mean),
        .head_flags (head_flags),
        .pop        (pop),
        .results    (results)
    );
endmodule

>>> src/wsaf_ram.sv
module wsaf_ram #(
    parameter int WIDTH = wsaf_pkg::SAMPLE_BITS_DEF + 1,
    parameter int DEPTH = wsaf_pkg::WINDOW_MAX_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> src/wsaf_regs.sv
module wsaf_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsaf_pkg::APB_AW-1:0]   paddr,
    input  logic [wsaf_pkg::APB_DW-1:0]   pwdata,
    output logic [wsaf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output wsaf_pkg::cfg_t                cfg
);
    import wsaf_pkg::*;

    logic               wr_en;
    logic               reg_idx;
    logic [THETA_W-1:0] theta_reg;
    logic [WLEN_W-1:0]  wlen_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_IDX_BIT];

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg <= THETA_RESET;
            wlen_reg  <= WLEN_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_THETA: theta_reg <= pwdata[THETA_W-1:0];
                REG_WLEN:  wlen_reg  <= pwdata[WLEN_W-1:0];
                default:   ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_THETA: prdata = APB_DW'(theta_reg);
            REG_WLEN:  prdata = APB_DW'(wlen_reg);
            default:   prdata = '0;
        endcase
    end

    // A new window length restarts the window
    assign cfg.theta = theta_reg;
    assign cfg.wlen  = wlen_reg;
    assign cfg.clear = wr_en && (reg_idx == REG_WLEN);
endmodule

>>> src/wsaf_front.sv
module wsaf_front #(
    parameter int SAMPLE_BITS = wsaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wsaf_sample_if.sink                   samples,
    output logic                          head_valid,
    output logic signed [SAMPLE_BITS-1:0] head_value,
    output logic signed [SAMPLE_BITS-1:0] head_mean,
    output wsaf_pkg::item_flags_t         head_flags,
    input  logic                          pop
);
    import wsaf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] q_value_reg [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] q_mean_reg  [QUEUE_DEPTH];
    item_flags_t                   q_flags_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]             wr_ptr_reg;
    logic [QPTR_W-1:0]             rd_ptr_reg;
    logic [QCNT_W-1:0]             count_reg;
    logic                          push;
    logic                          do_pop;
    item_flags_t                   in_flags;

    assign samples.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = samples.valid && samples.ready;
    assign head_valid    = (count_reg != '0);
    assign do_pop        = pop && head_valid;

    // Classify the incoming request
    assign in_flags.present    = samples.sample_present;
    assign in_flags.new_stream = samples.new_stream;

    // Store accepted requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_value_reg[wr_ptr_reg] <= samples.sample_value;
            q_mean_reg[wr_ptr_reg]  <= samples.window_mean;
            q_flags_reg[wr_ptr_reg] <= in_flags;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Present the oldest request
    assign head_value = q_value_reg[rd_ptr_reg];
    assign head_mean  = q_mean_reg[rd_ptr_reg];
    assign head_flags = q_flags_reg[rd_ptr_reg];
endmodule

>>> src/wsaf_back.sv
module wsaf_back #(
    parameter int WINDOW_MAX  = wsaf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = wsaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsaf_pkg::cfg_t                cfg,
    input  logic                          head_valid,
    input  logic signed [SAMPLE_BITS-1:0] head_value,
    input  logic signed [SAMPLE_BITS-1:0] head_mean,
    input  wsaf_pkg::item_flags_t         head_flags,
    output logic                          pop,
    wsaf_result_if.source                 results
);
    import wsaf_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int LW    = (CW > WLEN_W) ? CW : WLEN_W;
    localparam int S1_W  = SB + CW;
    localparam int S2_W  = 2 * SB + CW - 1;
    localparam int D_W   = SB + 1;
    localparam int ND_W  = D_W + CW;
    localparam int DEV_W = 2 * SB + CW;
    localparam int H_W   = (DEV_W + 1) / 2;
    localparam int CMP_W = DEV_W + T2_W;
    localparam int OP_A  = (S1_W > ND_W) ? S1_W : ND_W;
    localparam int OP_B  = (H_W > T2_W) ? H_W + 1 : T2_W + 1;
    localparam int OP_W  = (OP_A > OP_B) ? OP_A : OP_B;

    back_state_t state_reg, state_next;

    // Window state
    logic [AW-1:0]          wp_reg;
    logic [CW-1:0]          fill_reg;
    logic [CW-1:0]          cnt_reg;
    logic signed [S1_W-1:0] s1_reg;
    logic [S2_W-1:0]        s2_reg;
    logic signed [SB-1:0]   last_reg;
    logic [WCNT_W-1:0]      wcnt_reg;

    // Current request and intermediate products
    logic signed [SB-1:0]     x_reg;
    logic signed [SB-1:0]     a_reg;
    logic                     p_reg;
    logic                     evict_reg;
    logic signed [2*OP_W-1:0] prod_reg;
    logic [T2_W-1:0]          t2_reg;
    logic [DEV_W:0]           p2_reg;
    logic [DEV_W-1:0]         dev_reg;
    logic [CMP_W-1:0]         lhs_reg;
    logic [CMP_W-1:0]         rlo_reg;
    logic [CMP_W-1:0]         rhs_reg;

    // Result register
    logic              res_valid_reg;
    logic              res_anom_reg;
    logic              res_empty_reg;
    logic [WCNT_W-1:0] res_start_reg;

    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [SB:0]            ram_wdata;
    logic [SB:0]            ram_rdata;
    logic signed [SB-1:0]   old_value;
    logic                   old_present;
    logic [LW-1:0]          wl_ext;
    logic [CW-1:0]          w_eff;
    logic [AW-1:0]          wp_eff;
    logic [CW-1:0]          fill_eff;
    logic [CW:0]            wp_ext;
    logic [CW:0]            w_ext;
    logic [CW:0]            addr_wide;
    logic [AW-1:0]          wp_inc;
    logic signed [D_W-1:0]  diff;
    logic [DEV_W:0]         dev_next;
    logic [CMP_W-1:0]       rhs_next;
    logic signed [OP_W-1:0] mul_a;
    logic signed [OP_W-1:0] mul_b;
    logic                   out_free;
    logic                   res_load;

    // Window store: value with its present bit
    wsaf_ram #(
        .WIDTH (SB + 1),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_wdata   = {p_reg, x_reg};
    assign old_value   = $signed(ram_rdata[SB-1:0]);
    assign old_present = ram_rdata[SB];

    // Clamp window length into one to WINDOW_MAX
    always_comb
    begin
        wl_ext = LW'(cfg.wlen);
        if (wl_ext == '0)
        begin
            w_eff = CW'(1);
        end
        else if (wl_ext > LW'(WINDOW_MAX))
        begin
            w_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CW'(wl_ext);
        end
    end

    // Locate the entry that leaves the window
    assign wp_eff    = head_flags.new_stream ? '0 : wp_reg;
    assign fill_eff  = head_flags.new_stream ? '0 : fill_reg;
    assign wp_ext    = (CW + 1)'(wp_eff);
    assign w_ext     = (CW + 1)'(w_eff);
    assign addr_wide = (wp_ext >= w_ext) ? wp_ext - w_ext
                                         : wp_ext + (CW + 1)'(WINDOW_MAX) - w_ext;
    assign ram_raddr = addr_wide[AW-1:0];
    assign wp_inc    = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;

    // Deviation of the last present sample and the window deviation sum
    assign diff     = D_W'(last_reg) - D_W'(a_reg);
    assign dev_next = (DEV_W + 1)'(s2_reg) - {p2_reg[DEV_W-1:0], 1'b0} + prod_reg[DEV_W:0];
    assign rhs_next = (CMP_W'(prod_reg) << H_W) + rlo_reg;

    assign out_free = !res_valid_reg || results.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     state_next = head_valid ? ST_SQ_OLD : ST_IDLE;
            ST_SQ_OLD:   state_next = ST_THETA;
            ST_THETA:    state_next = (fill_reg == w_eff) ? ST_SUM_MEAN : ST_IDLE;
            ST_SUM_MEAN: state_next = ST_CNT_MEAN;
            ST_CNT_MEAN: state_next = ST_MEAN_SQ;
            ST_MEAN_SQ:  state_next = ST_CNT_DIFF;
            ST_CNT_DIFF: state_next = ST_DIFF_SQ;
            ST_DIFF_SQ:  state_next = ST_DEV_LO;
            ST_DEV_LO:   state_next = ST_DEV_HI;
            ST_DEV_HI:   state_next = ST_RHS;
            ST_RHS:      state_next = ST_RESULT;
            ST_RESULT:   state_next = out_free ? ST_IDLE : ST_RESULT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop, store access, multiplier operands
    always_comb
    begin
        pop      = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        res_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                pop    = head_valid;
                ram_re = head_valid;
                mul_a  = OP_W'(head_value);
                mul_b  = OP_W'(head_value);
            end
            ST_SQ_OLD:
            begin
                ram_we = 1'b1;
                mul_a  = OP_W'(old_value);
                mul_b  = OP_W'(old_value);
            end
            ST_THETA:
            begin
                mul_a = OP_W'($signed({1'b0, cfg.theta}));
                mul_b = OP_W'($signed({1'b0, cfg.theta}));
            end
            ST_SUM_MEAN:
            begin
                mul_a = OP_W'(s1_reg);
                mul_b = OP_W'(a_reg);
            end
            ST_CNT_MEAN:
            begin
                mul_a = OP_W'($signed({1'b0, cnt_reg}));
                mul_b = OP_W'(a_reg);
            end
            ST_MEAN_SQ:
            begin
                mul_a = $signed(prod_reg[OP_W-1:0]);
                mul_b = OP_W'(a_reg);
            end
            ST_CNT_DIFF:
            begin
                mul_a = OP_W'($signed({1'b0, cnt_reg}));
                mul_b = OP_W'(diff);
            end
            ST_DIFF_SQ:
            begin
                mul_a = $signed(prod_reg[OP_W-1:0]);
                mul_b = OP_W'(diff);
            end
            ST_DEV_LO:
            begin
                mul_a = OP_W'($signed({1'b0, dev_reg[H_W-1:0]}));
                mul_b = OP_W'($signed({1'b0, t2_reg}));
            end
            ST_DEV_HI:
            begin
                mul_a = OP_W'($signed({1'b0, dev_reg[DEV_W-1:H_W]}));
                mul_b = OP_W'($signed({1'b0, t2_reg}));
            end
            ST_RHS:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            ST_RESULT:
            begin
                res_load = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Advance state, update window totals, hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            last_reg      <= '0;
            wcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && head_flags.new_stream)
                    begin
                        wp_reg   <= '0;
                        fill_reg <= '0;
                        cnt_reg  <= '0;
                        s1_reg   <= '0;
                        s2_reg   <= '0;
                        last_reg <= '0;
                        wcnt_reg <= '0;
                    end
                end
                ST_SQ_OLD:
                begin
                    wp_reg <= wp_inc;
                    if (fill_reg < w_eff)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    if (p_reg)
                    begin
                        s1_reg   <= s1_reg + S1_W'(x_reg);
                        s2_reg   <= s2_reg + prod_reg[S2_W-1:0];
                        cnt_reg  <= cnt_reg + 1'b1;
                        last_reg <= x_reg;
                    end
                end
                ST_THETA:
                begin
                    if (evict_reg && old_present)
                    begin
                        s1_reg  <= s1_reg - S1_W'(old_value);
                        s2_reg  <= s2_reg - prod_reg[S2_W-1:0];
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_RESULT:
                begin
                    if (res_load)
                    begin
                        wcnt_reg <= wcnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    wcnt_reg <= wcnt_reg;
                end
            endcase

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            // Restart the window on a new window length
            if (cfg.clear)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
                cnt_reg  <= '0;
                s1_reg   <= '0;
                s2_reg   <= '0;
                last_reg <= '0;
                wcnt_reg <= '0;
            end
        end
    end

    // Shared multiplier and the products it leaves behind
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    x_reg     <= head_value;
                    a_reg     <= head_mean;
                    p_reg     <= head_flags.present;
                    evict_reg <= (fill_eff == w_eff);
                end
            end
            ST_SUM_MEAN: t2_reg  <= prod_reg[T2_W-1:0];
            ST_CNT_MEAN: p2_reg  <= prod_reg[DEV_W:0];
            ST_CNT_DIFF: dev_reg <= dev_next[DEV_W-1:0];
            ST_DEV_LO:   lhs_reg <= CMP_W'({prod_reg[DEV_W-1:0], {Q_SHIFT{1'b0}}});
            ST_DEV_HI:   rlo_reg <= CMP_W'(prod_reg);
            ST_RHS:      rhs_reg <= rhs_next;
            default:     ;
        endcase
    end

    // Form the result: flag unless the window is empty or strictly inside the band
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_empty_reg <= (cnt_reg == '0);
            res_anom_reg  <= (cnt_reg != '0) && !(lhs_reg < rhs_reg);
            res_start_reg <= wcnt_reg;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.is_anomaly   = res_anom_reg;
    assign results.empty_window = res_empty_reg;
    assign results.window_start = res_start_reg;
endmodule

>>> tb/sv/tb_window_sigma_anomaly_flag.sv
`timescale 1ns / 1ps

module tb_window_sigma_anomaly_flag;
    import wsaf_pkg::*;

    localparam int     SW        = SAMPLE_BITS_DEF;
    localparam int     WMAX      = WINDOW_MAX_DEF;
    localparam longint SAMPLE_HI = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_LO = -(longint'(1) <<< (SW - 1));

    typedef struct {
        logic signed [SW-1:0] value;
        bit                   present;
        logic signed [SW-1:0] mean;
        bit                   restart;
    } sample_req_t;

    typedef struct {
        bit                anomaly;
        bit                empty;
        logic [WCNT_W-1:0] start;
    } flag_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    wsaf_sample_if #(.SAMPLE_BITS(SW)) sample_ch ();
    wsaf_result_if result_ch ();

    window_sigma_anomaly_flag #(
        .WINDOW_MAX  (WMAX),
        .SAMPLE_BITS (SW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Window predictor state
    logic signed [SW-1:0] win_value [WMAX];
    bit                   win_present [WMAX];
    int                   wr_ptr;
    int                   fill;
    logic signed [SW-1:0] last_value;
    logic [WCNT_W-1:0]    win_count;
    logic [THETA_W-1:0]   theta_cfg = THETA_RESET;
    logic [WLEN_W-1:0]    wlen_cfg  = WLEN_RESET;

    flag_result_t flag_expect_q [$];
    int           mismatch_count = 0;
    bit           idling_on = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void clear_window_state();
        wr_ptr     = 0;
        fill       = 0;
        last_value = '0;
        win_count  = '0;
    endfunction

    function automatic logic signed [SW-1:0] clamp_sample(input longint v);
        if (v > SAMPLE_HI)
            return SW'(SAMPLE_HI);
        if (v < SAMPLE_LO)
            return SW'(SAMPLE_LO);
        return SW'(v);
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic sample_req_t sample_req(input longint value, input bit present,
                                               input longint mean, input bit restart);
        sample_req_t r;
        r.value   = SW'(value);
        r.present = present;
        r.mean    = SW'(mean);
        r.restart = restart;
        return r;
    endfunction

    // Advance the window by one accepted sample and queue the flag it yields
    function automatic void advance_window(input sample_req_t r);
        int                w;
        int                n;
        int                idx;
        longint            diff;
        longint unsigned   mag;
        logic [127:0]      dev_sum;
        logic [127:0]      lhs;
        logic [127:0]      rhs;
        flag_result_t      res;
        w = (wlen_cfg == 0) ? 1 : ((wlen_cfg > WMAX) ? WMAX : int'(wlen_cfg));
        if (r.restart)
            clear_window_state();
        win_value[wr_ptr]   = r.value;
        win_present[wr_ptr] = r.present;
        wr_ptr = (wr_ptr + 1) % WMAX;
        if (fill < w)
            fill++;
        if (r.present)
            last_value = r.value;
        if (fill < w)
            return;

        // Sum squared deviations over the present samples of the window
        n       = 0;
        dev_sum = '0;
        for (int k = 1; k <= w; k++)
        begin
            idx = (wr_ptr + WMAX - k) % WMAX;
            if (win_present[idx])
            begin
                diff    = longint'(win_value[idx]) - longint'(r.mean);
                mag     = (diff < 0) ? -diff : diff;
                dev_sum = dev_sum + 128'(mag * mag);
                n++;
            end
        end

        if (n == 0)
        begin
            res.anomaly = 1'b0;
            res.empty   = 1'b1;
        end
        else
        begin
            diff = longint'(last_value) - longint'(r.mean);
            mag  = (diff < 0) ? -diff : diff;
            lhs  = (128'(mag * mag) * 128'(n)) << Q_SHIFT;
            rhs  = dev_sum * (128'(theta_cfg) * 128'(theta_cfg));
            res.anomaly = !(lhs < rhs);
            res.empty   = 1'b0;
        end
        res.start = win_count;
        win_count = win_count + 1'b1;
        flag_expect_q.push_back(res);
    endfunction

    // Drop valid and wait until every expected flag is out and the back end settles
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (flag_expect_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // APB write, only with the block idle
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << APB_IDX_BIT;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == REG_THETA)
            theta_cfg = data[THETA_W-1:0];
        else
        begin
            wlen_cfg = data[WLEN_W-1:0];
            clear_window_state();
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Send one request; called and returning at a falling edge
    task automatic send_sample(input sample_req_t r);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.sample_value   <= r.value;
        sample_ch.sample_present <= r.present;
        sample_ch.window_mean    <= r.mean;
        sample_ch.new_stream     <= r.restart;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        advance_window(r);
        @(negedge clk);
    endtask

    // Window not yet full after reset: no flags
    task automatic test_not_full();
        send_sample(sample_req(100, 1'b1, 90, 1'b0));
        send_sample(sample_req(-50, 1'b1, 0, 1'b0));
        send_sample(sample_req(7, 1'b0, 3, 1'b0));
    endtask

    // Length zero acts as one: field extremes, zero deviation, empty window
    task automatic test_single_sample_window();
        write_reg(REG_WLEN, 0);
        send_sample(sample_req(SAMPLE_HI, 1'b1, SAMPLE_LO, 1'b0));
        send_sample(sample_req(SAMPLE_LO, 1'b1, SAMPLE_HI, 1'b0));
        send_sample(sample_req(12345, 1'b1, 12345, 1'b0));
        send_sample(sample_req(-1, 1'b0, 0, 1'b0));
        send_sample(sample_req(0, 1'b1, 0, 1'b1));
    endtask

    // Zero theta always flags; largest theta widens the band
    task automatic test_theta_extremes();
        write_reg(REG_WLEN, 2);
        write_reg(REG_THETA, 0);
        send_sample(sample_req(100, 1'b1, 0, 1'b0));
        send_sample(sample_req(-100, 1'b1, 0, 1'b0));
        send_sample(sample_req(300, 1'b1, 10, 1'b0));
        write_reg(REG_THETA, (1 << THETA_W) - 1);
        send_sample(sample_req(100, 1'b1, 0, 1'b0));
        send_sample(sample_req(-100, 1'b1, 0, 1'b0));
        send_sample(sample_req(SAMPLE_HI, 1'b1, 0, 1'b0));
    endtask

    // new_stream restarts the window and the index
    task automatic test_restart();
        write_reg(REG_THETA, THETA_RESET);
        write_reg(REG_WLEN, 3);
        send_sample(sample_req(10, 1'b1, 12, 1'b0));
        send_sample(sample_req(14, 1'b1, 12, 1'b0));
        send_sample(sample_req(11, 1'b0, 12, 1'b0));
        send_sample(sample_req(900, 1'b1, 12, 1'b0));
        send_sample(sample_req(-20, 1'b1, -18, 1'b1));
        send_sample(sample_req(-16, 1'b1, -18, 1'b0));
        send_sample(sample_req(-19, 1'b1, -18, 1'b0));
    endtask

    // Sensor-like stream around a random level, with outliers, gaps and noise
    task automatic test_random_phase(input int theta, input int wlen, input int count,
                                     input bit gaps);
        sample_req_t          r;
        logic signed [SW-1:0] raw;
        longint               base;
        longint               amp;
        int                   pick;
        write_reg(REG_THETA, theta);
        write_reg(REG_WLEN, wlen);
        idling_on = gaps;
        raw  = SW'($urandom);
        base = raw;
        amp  = ($urandom_range(0, 7) == 0) ? 0 : (longint'(1) << $urandom_range(0, 20));
        for (int i = 0; i < count; i++)
        begin
            pick      = $urandom_range(0, 99);
            r.present = 1'b1;
            r.restart = ($urandom_range(0, 79) == 0);
            if (pick < 8)
            begin
                r.value   = SW'($urandom);
                r.mean    = SW'($urandom);
                r.present = 1'($urandom);
                r.restart = ($urandom_range(0, 7) == 0);
            end
            else
            begin
                r.value = clamp_sample(base + jitter(amp));
                if (pick < 18)
                    r.value = clamp_sample(base + ($urandom_range(0, 1) ? 1 : -1) *
                                           (amp + 1) * longint'($urandom_range(4, 40)));
                else if (pick < 28)
                    r.present = 1'b0;
                r.mean = clamp_sample(base + jitter(amp / 4));
            end
            send_sample(r);
        end
    endtask

    // Result sink with bursts of backpressure
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted flag with the oldest prediction
    always @(posedge clk)
    begin : check_flags
        flag_result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (flag_expect_q.size() == 0)
                log_mismatch($sformatf("unexpected result, window_start=%0d",
                                       result_ch.window_start));
            else
            begin
                want = flag_expect_q.pop_front();
                if (result_ch.is_anomaly !== want.anomaly)
                    log_mismatch($sformatf("is_anomaly %b, want %b (window_start %0d)",
                                           result_ch.is_anomaly, want.anomaly, want.start));
                if (result_ch.empty_window !== want.empty)
                    log_mismatch($sformatf("empty_window %b, want %b (window_start %0d)",
                                           result_ch.empty_window, want.empty, want.start));
                if (result_ch.window_start !== want.start)
                    log_mismatch($sformatf("window_start %0d, want %0d",
                                           result_ch.window_start, want.start));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : run_tests
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.sample_value   = '0;
        sample_ch.sample_present = 1'b0;
        sample_ch.window_mean    = '0;
        sample_ch.new_stream     = 1'b0;
        clear_window_state();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idling_on = 1'b1;
        test_not_full();
        test_single_sample_window();
        test_theta_extremes();
        test_restart();

        test_random_phase(THETA_RESET, WLEN_RESET, 200, 1'b1);
        test_random_phase((1 << THETA_W) - 1, (1 << WLEN_W) - 1, 200, 1'b1);
        test_random_phase(0, 4, 80, 1'b1);
        test_random_phase(256, 1, 100, 1'b1);
        test_random_phase(1000, 0, 80, 1'b1);
        test_random_phase(384, WMAX, 150, 1'b0);
        for (int p = 0; p < 6; p++)
            test_random_phase($urandom_range(0, (1 << THETA_W) - 1), $urandom_range(1, 24),
                              80, 1'b1);
        test_random_phase($urandom_range(128, 1536), 8, 200, 1'b0);

        drain_results();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
src/wsaf_pkg.sv
src/wsaf_sample_if.sv
src/wsaf_result_if.sv
src/wsaf_ram.sv
src/wsaf_regs.sv
src/wsaf_front.sv
src/wsaf_back.sv
src/window_sigma_anomaly_flag.sv
tb/sv/tb_window_sigma_anomaly_flag.sv
